// ===== hdl/mmh_pkg.sv =====
`default_nettype none

package mmh_pkg;

  localparam int KEY_W   = 16;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = KEY_W + TAG_W;
  localparam int COUNT_W = 11;

  // request action codes
  localparam logic ACT_CLEAR  = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // heap_mode codes
  localparam logic MODE_PLAIN  = 1'b0;
  localparam logic MODE_MINMAX = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PARENT,
    ST_CLIMB,
    ST_PLACE,
    ST_RD_ROOT,
    ST_RD_LAST,
    ST_RD_LEFT,
    ST_CAP_LEFT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic               insert;
    logic               plain;
    logic               pos_min;
    logic               empty;
    logic               full_error;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]   root_key;
    logic [TAG_W-1:0]   root_tag;
    logic [KEY_W-1:0]   last_key;
    logic [TAG_W-1:0]   last_tag;
    logic [KEY_W-1:0]   leftmost_key;
    logic [TAG_W-1:0]   leftmost_tag;
    logic [COUNT_W-1:0] count;
    logic               full_error;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/mmh_if.sv =====
`default_nettype none

interface mmh_req_if
  import mmh_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;

  modport source (output valid, action, key, tag, input ready);
  modport sink   (input valid, action, key, tag, output ready);
endinterface

interface mmh_rsp_if
  import mmh_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   root_key;
  logic [TAG_W-1:0]   root_tag;
  logic [KEY_W-1:0]   last_key;
  logic [TAG_W-1:0]   last_tag;
  logic [KEY_W-1:0]   leftmost_key;
  logic [TAG_W-1:0]   leftmost_tag;
  logic [COUNT_W-1:0] count;
  logic               full_error;

  modport source (output valid, root_key, root_tag, last_key, last_tag, leftmost_key,
                  leftmost_tag, count, full_error, input ready);
  modport sink   (input valid, root_key, root_tag, last_key, last_tag, leftmost_key,
                  leftmost_tag, count, full_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/min_max_heap_insert.sv =====
// latency, accept to result valid: min-max insert 7 + one per grandparent compare,
//   plain insert 6 + one per parent compare, at most log2(CAPACITY) + 6; clear 1, rejected 5
// throughput: one request at a time, the next is taken one cycle after the result moves
//   to the output register; the single read port of the store gives one compare a cycle
// reset: count cleared, heap_mode set to min-max, result register emptied;
//   the entry store is not cleared, entries at or beyond the count are never read
`default_nettype none

module min_max_heap_insert
  import mmh_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  cfg_we,
  input wire logic  cfg_wdata,
  mmh_req_if.sink   req,
  mmh_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // configuration register
  logic heap_mode;

  // occupancy tracking
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [AW-1:0] lm_idx;       // first position of the deepest level
  logic [AW-1:0] lm_idx_next;
  logic          pos_odd;      // level parity of the next free position
  logic          pos_odd_next;

  // output register
  logic out_valid;
  res_t out_res;

  // request decode
  logic          accept;
  logic          is_full;
  logic          do_ins;
  logic [CW-1:0] cnt_inc;
  logic          cnt_inc_pow2;
  logic [CW:0]   pos_p1;
  logic [CW:0]   pos_p2;
  logic          level_step;
  logic [CW-1:0] last_wide;
  logic [CW+COUNT_W-1:0] cnt_ext;

  // sequencer and store wiring
  cmd_t               cmd;
  entry_t             item;
  logic               seq_idle;
  logic               seq_res_valid;
  res_t               seq_res;
  logic               res_take;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // a request is only taken with the sequencer idle; the output register
  // lets the next request in while a result still waits downstream
  assign req.ready = seq_idle;
  assign accept    = req.valid && req.ready;

  assign is_full = (cnt == CW'(CAPACITY));
  assign do_ins  = (req.action == ACT_INSERT) && !is_full;

  // new count a power of two: the inserted entry opens a new level
  assign cnt_inc      = cnt + CW'(1);
  assign cnt_inc_pow2 = ((cnt_inc & cnt) == '0);

  // level of the next free position moves down when position+2 is a power of two
  assign pos_p1     = {1'b0, cnt} + (CW+1)'(1);
  assign pos_p2     = {1'b0, cnt} + (CW+1)'(2);
  assign level_step = ((pos_p2 & pos_p1) == '0);

  always_comb begin
    cnt_next     = cnt;
    lm_idx_next  = lm_idx;
    pos_odd_next = pos_odd;
    if (req.action == ACT_CLEAR) begin
      cnt_next     = '0;
      lm_idx_next  = '0;
      pos_odd_next = 1'b0;
    end else if (do_ins) begin
      cnt_next     = cnt_inc;
      lm_idx_next  = cnt_inc_pow2 ? cnt[AW-1:0] : lm_idx;
      pos_odd_next = pos_odd ^ level_step;
    end
  end

  assign last_wide = cnt_next - CW'(1);
  assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_next};

  always_comb begin
    cmd            = '0;
    cmd.insert     = do_ins;
    cmd.plain      = (heap_mode == MODE_PLAIN);
    cmd.pos_min    = !pos_odd;
    cmd.empty      = (cnt_next == '0);
    cmd.full_error = (req.action == ACT_INSERT) && is_full;
    cmd.count      = cnt_ext[COUNT_W-1:0];
  end

  assign item.key = req.key;
  assign item.tag = req.tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_mode <= MODE_MINMAX;
    end else if (cfg_we) begin
      heap_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      lm_idx  <= '0;
      pos_odd <= 1'b0;
    end else if (accept) begin
      cnt     <= cnt_next;
      lm_idx  <= lm_idx_next;
      pos_odd <= pos_odd_next;
    end
  end

  // sift-up and readout sequencer around the entry store
  mmh_seq #(
    .AW (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .cmd       (cmd),
    .item      (item),
    .pos       (cnt[AW-1:0]),
    .last_idx  (last_wide[AW-1:0]),
    .left_idx  (lm_idx_next),
    .idle      (seq_idle),
    .res_valid (seq_res_valid),
    .res       (seq_res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // key and tag of each position, one write and one read port
  mmh_ram #(
    .AW (AW),
    .DW (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register, refilled as soon as it is empty or being drained
  assign res_take = seq_res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= seq_res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.root_key     = out_res.root_key;
  assign rsp.root_tag     = out_res.root_tag;
  assign rsp.last_key     = out_res.last_key;
  assign rsp.last_tag     = out_res.last_tag;
  assign rsp.leftmost_key = out_res.leftmost_key;
  assign rsp.leftmost_tag = out_res.leftmost_tag;
  assign rsp.count        = out_res.count;
  assign rsp.full_error   = out_res.full_error;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_CLEAR) |=> (cnt == '0 && lm_idx == '0 && !pos_odd))
    else $error("clear did not empty the heap");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && do_ins) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not bump the count");

endmodule

`default_nettype wire

// ===== hdl/mmh_ram.sv =====
`default_nettype none

module mmh_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1 << AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mmh_seq.sv =====
`default_nettype none

module mmh_seq
  import mmh_pkg::*;
#(
  parameter int AW = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire cmd_t               cmd,
  input  wire entry_t             item,
  input  wire logic [AW-1:0]      pos,
  input  wire logic [AW-1:0]      last_idx,
  input  wire logic [AW-1:0]      left_idx,
  output      logic               idle,
  output      logic               res_valid,
  output      res_t               res,
  input  wire logic               res_take,
  output      logic               ram_we,
  output      logic [AW-1:0]      ram_waddr,
  output      logic [ENTRY_W-1:0] ram_wdata,
  output      logic               ram_re,
  output      logic [AW-1:0]      ram_raddr,
  input  wire logic [ENTRY_W-1:0] ram_rdata
);

  seq_state_t state, state_next;

  entry_t        item_r;
  logic [AW-1:0] hole;
  logic [AW-1:0] anc;
  logic [AW-1:0] last_r;
  logic [AW-1:0] left_r;
  logic          plain_r;
  logic          pos_min_r;
  logic          want_min;
  res_t          res_r;

  entry_t        rd;
  logic          lt;
  logic          gt;
  logic          par_swap;
  logic          climb_move;
  logic [AW-1:0] base;
  logic [AW-1:0] up_par;
  logic [AW-1:0] up_grand;
  logic          use_par;
  logic [AW-1:0] nxt_anc;
  logic          cont;

  assign rd         = entry_t'(ram_rdata);
  assign lt         = item_r.key < rd.key;
  assign gt         = item_r.key > rd.key;
  assign par_swap   = pos_min_r ? gt : lt;
  assign climb_move = (plain_r || want_min) ? lt : gt;

  // position the new entry would sit at after this step
  always_comb begin
    unique case (state)
      ST_IDLE:   base = pos;
      ST_PARENT: base = par_swap ? anc : hole;
      default:   base = anc;
    endcase
  end

  assign up_par   = (base - AW'(1)) >> 1;
  assign up_grand = (up_par - AW'(1)) >> 1;
  // first step and plain mode go to the parent, min-max climbs by grandparents
  assign use_par  = (state == ST_IDLE) || plain_r;
  assign nxt_anc  = use_par ? up_par : up_grand;
  assign cont     = use_par ? (base != '0) : (base >= AW'(3));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.insert) begin
            state_next = cont ? (cmd.plain ? ST_CLIMB : ST_PARENT) : ST_PLACE;
          end else begin
            state_next = cmd.empty ? ST_DONE : ST_RD_ROOT;
          end
        end
      end
      ST_PARENT:   state_next = cont ? ST_CLIMB : ST_PLACE;
      ST_CLIMB:    state_next = (climb_move && cont) ? ST_CLIMB : ST_PLACE;
      ST_PLACE:    state_next = ST_RD_ROOT;
      ST_RD_ROOT:  state_next = ST_RD_LAST;
      ST_RD_LAST:  state_next = ST_RD_LEFT;
      ST_RD_LEFT:  state_next = ST_CAP_LEFT;
      ST_CAP_LEFT: state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = hole;
    ram_wdata = ram_rdata;
    ram_raddr = nxt_anc;
    unique case (state)
      ST_IDLE: begin
        ram_re = start && cmd.insert && cont;
      end
      ST_PARENT: begin
        ram_we = par_swap;
        ram_re = cont;
      end
      ST_CLIMB: begin
        ram_we = climb_move;
        ram_re = climb_move && cont;
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = ENTRY_W'(item_r);
      end
      ST_RD_ROOT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_RD_LAST: begin
        ram_re    = 1'b1;
        ram_raddr = last_r;
      end
      ST_RD_LEFT: begin
        ram_re    = 1'b1;
        ram_raddr = left_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          item_r    <= item;
          hole      <= pos;
          anc       <= nxt_anc;
          plain_r   <= cmd.plain;
          pos_min_r <= cmd.pos_min;
          want_min  <= cmd.pos_min;
          last_r    <= last_idx;
          left_r    <= left_idx;
          res_r.root_key     <= '0;
          res_r.root_tag     <= '0;
          res_r.last_key     <= '0;
          res_r.last_tag     <= '0;
          res_r.leftmost_key <= '0;
          res_r.leftmost_tag <= '0;
          res_r.count        <= cmd.count;
          res_r.full_error   <= cmd.full_error;
        end
      end
      ST_PARENT: begin
        hole     <= base;
        anc      <= nxt_anc;
        want_min <= par_swap ? !pos_min_r : pos_min_r;
      end
      ST_CLIMB: begin
        if (climb_move) begin
          hole <= anc;
          anc  <= nxt_anc;
        end
      end
      ST_RD_LAST: begin
        res_r.root_key <= rd.key;
        res_r.root_tag <= rd.tag;
      end
      ST_RD_LEFT: begin
        res_r.last_key <= rd.key;
        res_r.last_tag <= rd.tag;
      end
      ST_CAP_LEFT: begin
        res_r.leftmost_key <= rd.key;
        res_r.leftmost_tag <= rd.tag;
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res       = res_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("store read and write hit the same entry");

  a_climb_goes_up: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLIMB && climb_move) |=> (hole < $past(hole)))
    else $error("sift step did not move toward the root");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_IDLE))
    else $error("request started while sequencer busy");

endmodule

`default_nettype wire
